// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ACPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACPU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/acpu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acpu_pkg;

  localparam int WORD_W = 24;
  localparam int ADDR_W = 20;
  localparam int CNT_W  = 32;
  localparam int STEP_W = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [STEP_W-1:0] step_t;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SETIA = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;

  // opcodes (bits 23..20) and extended subcodes (bits 19..16)
  localparam logic [3:0] OP_LDC = 4'h0;
  localparam logic [3:0] OP_LDV = 4'h1;
  localparam logic [3:0] OP_STV = 4'h2;
  localparam logic [3:0] OP_ADD = 4'h3;
  localparam logic [3:0] OP_AND = 4'h4;
  localparam logic [3:0] OP_OR  = 4'h5;
  localparam logic [3:0] OP_XOR = 4'h6;
  localparam logic [3:0] OP_EQL = 4'h7;
  localparam logic [3:0] OP_JMP = 4'h8;
  localparam logic [3:0] OP_JMN = 4'h9;
  localparam logic [3:0] OP_EXT = 4'hF;

  localparam logic [3:0] SUB_HALT = 4'h0;
  localparam logic [3:0] SUB_NOT  = 4'h1;
  localparam logic [3:0] SUB_RAR  = 4'h2;

  // microprogram step addresses
  localparam step_t S_CLR   = 5'd0;
  localparam step_t S_IDLE  = 5'd1;
  localparam step_t S_WR    = 5'd2;
  localparam step_t S_WR_W  = 5'd3;
  localparam step_t S_WR_M  = 5'd4;
  localparam step_t S_SETIA = 5'd5;
  localparam step_t S_RD    = 5'd6;
  localparam step_t S_RD_W  = 5'd7;
  localparam step_t S_RD_M  = 5'd8;
  localparam step_t S_RD_D  = 5'd9;
  localparam step_t S_EX    = 5'd10;
  localparam step_t S_EX_W  = 5'd11;
  localparam step_t S_EX_F  = 5'd12;
  localparam step_t S_EX_IR = 5'd13;
  localparam step_t S_DEC   = 5'd14;
  localparam step_t S_LDC   = 5'd15;
  localparam step_t S_JMP   = 5'd16;
  localparam step_t S_JMN   = 5'd17;
  localparam step_t S_NOT   = 5'd18;
  localparam step_t S_RAR   = 5'd19;
  localparam step_t S_HALT  = 5'd20;
  localparam step_t S_UNDEF = 5'd21;
  localparam step_t S_STV   = 5'd22;
  localparam step_t S_STV_W = 5'd23;
  localparam step_t S_STV_M = 5'd24;
  localparam step_t S_OPD   = 5'd25;
  localparam step_t S_OPD_W = 5'd26;
  localparam step_t S_OPD_M = 5'd27;
  localparam step_t S_OPD_A = 5'd28;
  localparam step_t S_OUT   = 5'd29;

  typedef enum logic [1:0] {SRC_IN, SRC_IA, SRC_IR} src_t;
  typedef enum logic [1:0] {WD_ZERO, WD_DATA, WD_ACC} wd_t;
  typedef enum logic [2:0] {IA_HOLD, IA_INC, IA_LOAD_IN, IA_LOAD_A, IA_LOAD_A_NEG} ia_op_t;
  typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD_A, ACC_MEM, ACC_NOT, ACC_RAR} acc_op_t;
  typedef enum logic [2:0] {
    C_NEXT, C_GOTO, C_WAIT_CLR, C_WAIT_BUSY, C_KIND, C_DECODE, C_OUT
  } cond_t;

  typedef struct packed {
    logic       mod_go;
    src_t       mod_src;
    logic       mem_rd;
    logic       mem_wr;
    wd_t        wd_sel;
    logic       addr_clr;
    logic       clr_inc;
    logic       ld_ir;
    logic       ld_rd;
    ia_op_t     ia_op;
    acc_op_t    acc_op;
    logic       ctr_inc;
    logic       st_ld;
    logic [1:0] st_code;
    cond_t      cond;
    step_t      target;
  } uword_t;

  typedef struct packed {
    logic       mod_busy;
    logic       clr_more;
    logic       cmd_fire;
    logic [1:0] kind;
    word_t      ir;
    logic       out_free;
  } flags_t;

  // control store
  function automatic uword_t ucode(input step_t s);
    uword_t uw;
    uw = '0;
    unique case (s)
      S_CLR: begin
        uw.mem_wr = 1'b1; uw.wd_sel = WD_ZERO; uw.addr_clr = 1'b1;
        uw.clr_inc = 1'b1; uw.cond = C_WAIT_CLR;
      end
      S_IDLE:  uw.cond = C_KIND;
      S_WR:    begin uw.mod_go = 1'b1; uw.mod_src = SRC_IN; end
      S_WR_W:  uw.cond = C_WAIT_BUSY;
      S_WR_M: begin
        uw.mem_wr = 1'b1; uw.wd_sel = WD_DATA; uw.cond = C_GOTO; uw.target = S_OUT;
      end
      S_SETIA: begin uw.ia_op = IA_LOAD_IN; uw.cond = C_GOTO; uw.target = S_OUT; end
      S_RD:    begin uw.mod_go = 1'b1; uw.mod_src = SRC_IN; end
      S_RD_W:  uw.cond = C_WAIT_BUSY;
      S_RD_M:  uw.mem_rd = 1'b1;
      S_RD_D:  begin uw.ld_rd = 1'b1; uw.cond = C_GOTO; uw.target = S_OUT; end
      S_EX:    begin uw.mod_go = 1'b1; uw.mod_src = SRC_IA; uw.ctr_inc = 1'b1; end
      S_EX_W:  uw.cond = C_WAIT_BUSY;
      S_EX_F:  begin uw.mem_rd = 1'b1; uw.ia_op = IA_INC; end
      S_EX_IR: uw.ld_ir = 1'b1;
      S_DEC:   uw.cond = C_DECODE;
      S_LDC:   begin uw.acc_op = ACC_LOAD_A; uw.cond = C_GOTO; uw.target = S_OUT; end
      S_JMP:   begin uw.ia_op = IA_LOAD_A; uw.cond = C_GOTO; uw.target = S_OUT; end
      S_JMN:   begin uw.ia_op = IA_LOAD_A_NEG; uw.cond = C_GOTO; uw.target = S_OUT; end
      S_NOT:   begin uw.acc_op = ACC_NOT; uw.cond = C_GOTO; uw.target = S_OUT; end
      S_RAR:   begin uw.acc_op = ACC_RAR; uw.cond = C_GOTO; uw.target = S_OUT; end
      S_HALT: begin
        uw.st_ld = 1'b1; uw.st_code = ST_HALT; uw.cond = C_GOTO; uw.target = S_OUT;
      end
      S_UNDEF: begin
        uw.st_ld = 1'b1; uw.st_code = ST_UNDEF; uw.cond = C_GOTO; uw.target = S_OUT;
      end
      S_STV:   begin uw.mod_go = 1'b1; uw.mod_src = SRC_IR; end
      S_STV_W: uw.cond = C_WAIT_BUSY;
      S_STV_M: begin
        uw.mem_wr = 1'b1; uw.wd_sel = WD_ACC; uw.cond = C_GOTO; uw.target = S_OUT;
      end
      S_OPD:   begin uw.mod_go = 1'b1; uw.mod_src = SRC_IR; end
      S_OPD_W: uw.cond = C_WAIT_BUSY;
      S_OPD_M: uw.mem_rd = 1'b1;
      S_OPD_A: begin uw.acc_op = ACC_MEM; uw.cond = C_GOTO; uw.target = S_OUT; end
      S_OUT:   begin uw.cond = C_OUT; uw.target = S_IDLE; end
      default: begin uw.cond = C_GOTO; uw.target = S_IDLE; end
    endcase
    return uw;
  endfunction

  // dispatch on the item kind
  function automatic step_t kind_target(input logic [1:0] kind);
    step_t t;
    unique case (kind)
      KIND_WRITE: t = S_WR;
      KIND_SETIA: t = S_SETIA;
      KIND_EXEC:  t = S_EX;
      KIND_READ:  t = S_RD;
    endcase
    return t;
  endfunction

  // dispatch on the fetched instruction
  function automatic step_t dec_target(input word_t ir);
    step_t t;
    unique case (ir[23:20])
      OP_LDC: t = S_LDC;
      OP_LDV, OP_ADD, OP_AND, OP_OR, OP_XOR, OP_EQL: t = S_OPD;
      OP_STV: t = S_STV;
      OP_JMP: t = S_JMP;
      OP_JMN: t = S_JMN;
      OP_EXT: begin
        unique case (ir[19:16])
          SUB_HALT: t = S_HALT;
          SUB_NOT:  t = S_NOT;
          SUB_RAR:  t = S_RAR;
          default:  t = S_UNDEF;
        endcase
      end
      default: t = S_UNDEF;
    endcase
    return t;
  endfunction

  // accumulator operations that take a memory operand
  function automatic word_t alu(input logic [3:0] op, input word_t acc, input word_t opnd);
    word_t r;
    unique case (op)
      OP_LDV:  r = opnd;
      OP_ADD:  r = acc + opnd;
      OP_AND:  r = acc & opnd;
      OP_OR:   r = acc | opnd;
      OP_XOR:  r = acc ^ opnd;
      default: r = {WORD_W{acc == opnd}};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/acpu_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface acpu_cmd_if import acpu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  addr_t      address;
  word_t      data;

  modport source(output valid, kind, address, data, input ready);
  modport sink(input valid, kind, address, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/acpu_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface acpu_rsp_if import acpu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  word_t            acc_value;
  addr_t            next_address;
  word_t            read_data;
  logic [CNT_W-1:0] executed_count;

  modport source(output valid, status, acc_value, next_address, read_data, executed_count,
                 input ready);
  modport sink(input valid, status, acc_value, next_address, read_data, executed_count,
               output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/acpu_addr_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Reduce a 20-bit address modulo MEM_DEPTH. Power-of-two depths take the low bits
// at once. Other depths estimate the quotient with a constant reciprocal, subtract
// quotient times depth, then correct once; busy stays high through these steps.
module acpu_addr_mod import acpu_pkg::*; #(
  parameter int MEM_DEPTH = 4096,
  localparam int IW = $clog2(MEM_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  addr_t         value,
  output logic          busy,
  output logic [IW-1:0] index
);

  localparam bit POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
  localparam int QW   = ADDR_W - IW + 2;
  localparam int PW   = ADDR_W + QW;
  // floor(2^20 / MEM_DEPTH): the estimate is the true quotient or one short
  localparam logic [QW-1:0] RECIP = QW'((64'd1 << ADDR_W) / MEM_DEPTH);
  localparam addr_t         DIV   = ADDR_W'(MEM_DEPTH);

  addr_t         rem;
  logic [QW-1:0] quot;
  logic [1:0]    phase;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] prod_d;

  assign prod_q = PW'(rem) * PW'(RECIP);
  assign prod_d = PW'(quot) * PW'(DIV);
  assign index  = rem[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else if (go) begin
      busy  <= !POW2;
      phase <= '0;
    end else if (busy) begin
      phase <= phase + 2'd1;
      if (phase == 2'd2) begin
        busy <= 1'b0;
      end
    end
  end

  // Estimate the quotient, subtract its multiple, then drop the one leftover divisor.
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= value;
    end else if (busy && phase == 2'd0) begin
      quot <= prod_q[PW-1:ADDR_W];
    end else if (busy && phase == 2'd1) begin
      rem <= rem - prod_d[ADDR_W-1:0];
    end else if (busy && rem >= DIV) begin
      rem <= rem - DIV;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/acpu_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-port word memory with registered read data.
module acpu_mem import acpu_pkg::*; #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  word_t         wdata,
  output word_t         rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/acpu_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Step counter and control store; branches on datapath flags.
module acpu_seq import acpu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output uword_t uw
);

  step_t step;
  step_t step_next;
  step_t step_inc;

  assign uw       = ucode(step);
  assign step_inc = step + step_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_CLR;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    unique case (uw.cond)
      C_NEXT:      step_next = step_inc;
      C_GOTO:      step_next = uw.target;
      C_WAIT_CLR:  step_next = flags.clr_more ? step : step_inc;
      C_WAIT_BUSY: step_next = flags.mod_busy ? step : step_inc;
      C_KIND:      step_next = flags.cmd_fire ? kind_target(flags.kind) : step;
      C_DECODE:    step_next = dec_target(flags.ir);
      C_OUT:       step_next = flags.out_free ? uw.target : step;
      default:     step_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/accumulator_cpu_24bit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// When MEM_DEPTH is no power of two, each memory access waits for the address reducer
// (two accesses for load, store and the memory operand operations).
// Items are taken one at a time, with one idle step between items.
// Reset (rst, synchronous) clears the state and control registers, then a clearing pass
// zeroes every memory word; no item is accepted until it ends.
`include "assert_macros.svh"

module accumulator_cpu_24bit import acpu_pkg::*; #(
  parameter int MEM_DEPTH = 4096
) (
  input wire logic  clk,
  input wire logic  rst,
  acpu_cmd_if.sink  cmd,
  acpu_rsp_if.source rsp
);

  localparam int AW = $clog2(MEM_DEPTH);

  // Control from the microcoded sequencer
  uword_t uw;
  flags_t flags;

  // Architectural state
  word_t            acc;
  addr_t            ia;
  word_t            ir;
  logic [CNT_W-1:0] ctr;

  // Per-item working registers
  addr_t      in_addr;
  word_t      in_data;
  logic [1:0] stat;
  word_t      rd;

  // Memory side
  logic [AW-1:0] clr_ptr;
  logic          clr_more;
  addr_t         mod_val;
  logic          mod_busy;
  logic [AW-1:0] mod_idx;
  logic [AW-1:0] mem_addr;
  word_t         mem_wdata;
  word_t         mem_rdata;

  // Handshakes and output register
  logic cmd_fire;
  logic out_free;
  logic out_valid;

  assign cmd.ready = (uw.cond == C_KIND);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign clr_more  = (clr_ptr != AW'(MEM_DEPTH - 1));
  assign rsp.valid = out_valid;

  assign flags = '{
    mod_busy: mod_busy,
    clr_more: clr_more,
    cmd_fire: cmd_fire,
    kind:     cmd.kind,
    ir:       ir,
    out_free: out_free
  };

  acpu_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uw    (uw)
  );

  // Pick the address to reduce: the item's address, the instruction pointer,
  // or the operand field of the fetched instruction.
  always_comb begin
    unique case (uw.mod_src)
      SRC_IA:  mod_val = ia;
      SRC_IR:  mod_val = ir[ADDR_W-1:0];
      default: mod_val = in_addr;
    endcase
  end

  acpu_addr_mod #(.MEM_DEPTH(MEM_DEPTH)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .go    (uw.mod_go),
    .value (mod_val),
    .busy  (mod_busy),
    .index (mod_idx)
  );

  // The clearing pass walks its own pointer; everything else uses the reduced index.
  assign mem_addr = uw.addr_clr ? clr_ptr : mod_idx;

  always_comb begin
    unique case (uw.wd_sel)
      WD_DATA: mem_wdata = in_data;
      WD_ACC:  mem_wdata = acc;
      default: mem_wdata = '0;
    endcase
  end

  acpu_mem #(.DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (uw.mem_wr),
    .re    (uw.mem_rd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Capture the item's payload at accept; the kind steers the sequencer directly.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      in_addr <= cmd.address;
      in_data <= cmd.data;
    end
  end

  // Clear pointer: advance one word a cycle during the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (uw.clr_inc) begin
      clr_ptr <= clr_ptr + AW'(1);
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      unique case (uw.acc_op)
        ACC_LOAD_A: acc <= {{(WORD_W - ADDR_W){1'b0}}, ir[ADDR_W-1:0]};
        ACC_MEM:    acc <= alu(ir[23:20], acc, mem_rdata);
        ACC_NOT:    acc <= ~acc;
        ACC_RAR:    acc <= {acc[0], acc[WORD_W-1:1]};
        default:    acc <= acc;
      endcase
    end
  end

  // Instruction pointer: advance on fetch, load on set/jump, conditional on sign for JMN.
  always_ff @(posedge clk) begin
    if (rst) begin
      ia <= '0;
    end else begin
      unique case (uw.ia_op)
        IA_INC:        ia <= ia + ADDR_W'(1);
        IA_LOAD_IN:    ia <= in_addr;
        IA_LOAD_A:     ia <= ir[ADDR_W-1:0];
        IA_LOAD_A_NEG: ia <= acc[WORD_W-1] ? ir[ADDR_W-1:0] : ia;
        default:       ia <= ia;
      endcase
    end
  end

  // Instruction register and instruction counter
  always_ff @(posedge clk) begin
    if (rst) begin
      ir  <= '0;
      ctr <= '0;
    end else begin
      if (uw.ld_ir) begin
        ir <= mem_rdata;
      end
      if (uw.ctr_inc) begin
        ctr <= ctr + CNT_W'(1);
      end
    end
  end

  // Status and read data start from zero for every item.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= ST_OK;
      rd   <= '0;
    end else begin
      if (cmd_fire) begin
        stat <= ST_OK;
        rd   <= '0;
      end else begin
        if (uw.st_ld) begin
          stat <= uw.st_code;
        end
        if (uw.ld_rd) begin
          rd <= mem_rdata;
        end
      end
    end
  end

  // Output register: load the result once the slot is free, then the sequencer
  // returns to idle and can take the next item while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.cond == C_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.cond == C_OUT && out_free) begin
      rsp.status         <= stat;
      rsp.acc_value      <= acc;
      rsp.next_address   <= ia;
      rsp.read_data      <= rd;
      rsp.executed_count <= ctr;
    end
  end

  // No command may be taken while memory is still being cleared.
  `ACPU_ASSERT_IMP(a_clr_blocks_cmd, clr_more && uw.clr_inc, !cmd.ready, "item taken during memory clear")
  // A memory access must never use an index the reducer is still working on.
  `ACPU_ASSERT_IMP(a_idx_settled, (uw.mem_rd || uw.mem_wr) && !uw.addr_clr, !mod_busy, "memory access before address reduced")
  // The instruction counter moves by exactly one per started instruction.
  `ACPU_ASSERT_NXT(a_ctr_step, uw.ctr_inc, ctr == $past(ctr) + CNT_W'(1), "instruction counter misstep")
  // Every accepted item starts with a clean status and read word.
  `ACPU_ASSERT_NXT(a_item_clean, cmd_fire, stat == ST_OK && rd == '0, "status or read data not cleared")

endmodule

`default_nettype wire
